@@ sv/priority_round_robin_thread_picker_macros.svh @@
// Assertion helpers used by the checker file.
`ifndef PRIORITY_ROUND_ROBIN_THREAD_PICKER_MACROS_SVH
`define PRIORITY_ROUND_ROBIN_THREAD_PICKER_MACROS_SVH

// Property sampled on clk, ignored while reset is held.
`define PRRTP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property sampled on clk, checked during reset as well.
`define PRRTP_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ sv/prrtp_pkg.sv @@
package prrtp_pkg;

  // Field widths of the stream and configuration words
  localparam int MASK_W      = 8;
  localparam int COUNT_W     = 4;
  localparam int LEVELS_W    = 16;
  localparam int INDEX_W     = 3;
  localparam int LEVEL_W     = 2;
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 8;
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 16;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_THREAD_CNT    = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_THREAD_LEVELS = 1'b1;

endpackage

@@ sv/priority_round_robin_thread_picker.sv @@
// Multi-level priority round-robin thread picker.
// Input stream: one word per request, in_tdata[7:0] is the runnable mask
// (bit i set when thread i may run). Output stream: one word per request,
// out_tuser is the found flag, out_tdata[2:0] the granted thread and
// out_tdata[4:3] its level (both zero when nothing was granted).
// Configuration: cfg_index 0 writes the thread count (cfg_data[3:0]),
// index 1 the per-thread levels (two bits each, thread 0 lowest). Write
// only while no request is in flight; cfg_ready is always high.
// Level 0 is searched first; within a level the search starts just after
// that level's last granted thread and wraps.
// A word is held in the input register, its result in the result register.
// Throughput: one word per cycle unless the output stalls; the last-served
// table is updated at the same edge that loads the result register, so the
// next word sees it. A stalled output holds its word; the input register
// still takes a word while the output one waits, then in_tready drops
// until out_tready. Reset (rst_n low, synchronous) empties both registers,
// clears the configuration and sets every last-served entry to
// NUM_THREADS - 1.
module priority_round_robin_thread_picker #(
  parameter int NUM_THREADS = 8,
  parameter int NUM_LEVELS  = 4
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // fields: runnable_mask [7:0]
  input  logic [prrtp_pkg::IN_TDATA_W-1:0]      in_tdata,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  // fields: grant_index [2:0], grant_level [4:3], zero [7:5]
  output logic [prrtp_pkg::OUT_TDATA_W-1:0]     out_tdata,
  // fields: grant_found [0]
  output logic                                  out_tuser,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [prrtp_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [prrtp_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int TW = (NUM_THREADS > 1) ? $clog2(NUM_THREADS) : 1;
  localparam int LW = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;

  // Configuration and per-level state
  logic [prrtp_pkg::COUNT_W-1:0]  thread_cnt_r;
  logic [prrtp_pkg::LEVELS_W-1:0] thread_levels_r;
  logic [TW-1:0]                  last_served_r [NUM_LEVELS];

  // Pipeline registers
  logic                           in_v_r;
  logic [prrtp_pkg::MASK_W-1:0]   mask_r;
  logic                           out_v_r;
  logic                           found_r;
  logic [prrtp_pkg::INDEX_W-1:0]  index_r;
  logic [prrtp_pkg::LEVEL_W-1:0]  level_r;

  // Selection network
  logic [NUM_THREADS-1:0]         run_ext;
  logic [NUM_THREADS-1:0]         cnt_ok;
  logic [2*NUM_THREADS-1:0]       lev_ext;
  logic [NUM_THREADS-1:0]         elig    [NUM_LEVELS];
  logic [NUM_THREADS-1:0]         hi_mask [NUM_LEVELS];
  logic [NUM_THREADS-1:0]         hi_vec  [NUM_LEVELS];
  logic [TW-1:0]                  pick_l  [NUM_LEVELS];
  logic [NUM_LEVELS-1:0]          any_l;
  logic [LW-1:0]                  sel_l;
  logic [TW-1:0]                  sel_t;
  logic                           found;
  logic                           advance;

  // Lowest set bit of a thread vector
  function automatic logic [TW-1:0] pick_low(input logic [NUM_THREADS-1:0] v);
    logic [TW-1:0] idx;
    idx = '0;
    for (int i = NUM_THREADS - 1; i >= 0; i--) begin
      if (v[i]) begin
        idx = TW'(i);
      end
    end
    return idx;
  endfunction

  // Widen mask and level fields to the thread count
  for (genvar t = 0; t < NUM_THREADS; t++) begin : g_thr
    if (t < prrtp_pkg::MASK_W) begin : g_run
      assign run_ext[t] = mask_r[t];
    end else begin : g_norun
      assign run_ext[t] = 1'b0;
    end
    if (2 * t < prrtp_pkg::LEVELS_W) begin : g_lev
      assign lev_ext[2*t +: 2] = thread_levels_r[2*t +: 2];
    end else begin : g_nolev
      assign lev_ext[2*t +: 2] = 2'd0;
    end
    assign cnt_ok[t] = int'(thread_cnt_r) > t;
  end

  // Eligible threads and the after-last-served window of each level
  for (genvar l = 0; l < NUM_LEVELS; l++) begin : g_lvl
    for (genvar t = 0; t < NUM_THREADS; t++) begin : g_cell
      assign elig[l][t]    = cnt_ok[t] && run_ext[t] && (int'(lev_ext[2*t +: 2]) == l);
      assign hi_mask[l][t] = int'(last_served_r[l]) < t;
    end
    assign hi_vec[l] = elig[l] & hi_mask[l];
    assign any_l[l]  = |elig[l];
    assign pick_l[l] = (|hi_vec[l]) ? pick_low(hi_vec[l]) : pick_low(elig[l]);
  end

  // Most urgent level with a candidate
  always_comb begin
    sel_l = '0;
    for (int l = NUM_LEVELS - 1; l >= 0; l--) begin
      if (any_l[l]) begin
        sel_l = LW'(l);
      end
    end
  end

  assign found   = |any_l;
  assign sel_t   = pick_l[sel_l];
  assign advance = in_v_r && (!out_v_r || out_tready);

  assign in_tready  = !in_v_r || advance;
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_v_r;
  assign out_tuser  = found_r;
  assign out_tdata  = prrtp_pkg::OUT_TDATA_W'({level_r, index_r});

  // Control state, configuration and last-served table
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r          <= 1'b0;
      out_v_r         <= 1'b0;
      thread_cnt_r    <= '0;
      thread_levels_r <= '0;
      for (int l = 0; l < NUM_LEVELS; l++) begin
        last_served_r[l] <= TW'(NUM_THREADS - 1);
      end
    end else begin
      if (in_tready) begin
        in_v_r <= in_tvalid;
      end
      if (advance) begin
        out_v_r <= 1'b1;
        if (found) begin
          last_served_r[sel_l] <= sel_t;
        end
      end else if (out_tready) begin
        out_v_r <= 1'b0;
      end
      if (cfg_valid) begin
        case (cfg_index)
          prrtp_pkg::CFG_THREAD_CNT: begin
            thread_cnt_r <= cfg_data[prrtp_pkg::COUNT_W-1:0];
          end
          prrtp_pkg::CFG_THREAD_LEVELS: begin
            thread_levels_r <= cfg_data[prrtp_pkg::LEVELS_W-1:0];
          end
          default: begin
          end
        endcase
      end
    end
  end

  // Payload: load the input word and the result word
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      mask_r <= in_tdata[prrtp_pkg::MASK_W-1:0];
    end
    if (advance) begin
      found_r <= found;
      index_r <= found ? prrtp_pkg::INDEX_W'(sel_t) : '0;
      level_r <= found ? prrtp_pkg::LEVEL_W'(sel_l) : '0;
    end
  end

endmodule

@@ sv/prrtp_checker.sv @@
`include "priority_round_robin_thread_picker_macros.svh"

module prrtp_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic [prrtp_pkg::IN_TDATA_W-1:0]  in_tdata,
  input logic                              in_tvalid,
  input logic                              in_tready,
  input logic [prrtp_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic                              out_tuser,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic                              cfg_valid,
  input logic                              cfg_ready,
  input logic [prrtp_pkg::CFG_INDEX_W-1:0] cfg_index,
  input logic [prrtp_pkg::CFG_DATA_W-1:0]  cfg_data
);

  logic [prrtp_pkg::COUNT_W-1:0]  count_r;
  logic [prrtp_pkg::LEVELS_W-1:0] levels_r;
  logic                           in_seen;

  assign in_seen = in_tvalid && in_tready && (in_tdata != '1 || in_tdata == '1);

  // Track the configuration seen on the port
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      levels_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        prrtp_pkg::CFG_THREAD_CNT: begin
          count_r <= cfg_data[prrtp_pkg::COUNT_W-1:0];
        end
        prrtp_pkg::CFG_THREAD_LEVELS: begin
          levels_r <= cfg_data[prrtp_pkg::LEVELS_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  `PRRTP_ASSERT(a_out_hold,
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser),
    "stalled output word changed")

  `PRRTP_ASSERT(a_no_grant_zero,
    out_tvalid && !out_tuser |-> out_tdata == '0,
    "empty grant carries nonzero fields")

  `PRRTP_ASSERT(a_grant_in_count,
    out_tvalid && out_tuser |-> {1'b0, out_tdata[2:0]} < count_r,
    "granted thread at or above thread count")

  `PRRTP_ASSERT(a_grant_level,
    out_tvalid && out_tuser |-> levels_r[2*out_tdata[2:0] +: 2] == out_tdata[4:3],
    "granted level differs from configured level")

  `PRRTP_ASSERT_ALWAYS(a_reset_empty,
    $past(!rst_n) && !in_seen |-> !out_tvalid,
    "output valid right after reset")

endmodule

bind priority_round_robin_thread_picker prrtp_checker u_prrtp_checker (.*);
